### design/gpmr_pkg.sv
// ----------------------------------------------------------------------------
// gpmr_pkg
// Shared constants, register indexes, types and request functions for the gamepad motor ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpmr_pkg;

    localparam int FRAME_DATA_BYTES = 6;
    localparam int DUTY_W           = 10;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_MAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_TRIES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_HIGH     = 3'd6;

    // Register values after reset.
    localparam logic [7:0]        RST_RAMP_STEP      = 8'd48;
    localparam logic [DUTY_W-1:0] RST_WHEEL_MAX      = 10'd1008;
    localparam logic [DUTY_W-1:0] RST_AUX_MAX        = 10'd960;
    localparam logic [7:0]        RST_START_BYTE     = 8'h80;
    localparam logic [3:0]        RST_CHECKSUM_TRIES = 4'd10;
    localparam logic [6:0]        RST_STICK_LOW      = 7'h0A;
    localparam logic [6:0]        RST_STICK_HIGH     = 7'h77;

    // Stick y codes for full forward and full reverse.
    localparam logic [7:0] STICK_Y_FWD = 8'h00;
    localparam logic [7:0] STICK_Y_REV = 8'h7F;

    typedef logic [1:0] req_t;

    localparam req_t REQ_NONE = 2'd0;
    localparam req_t REQ_FWD  = 2'd1;
    localparam req_t REQ_REV  = 2'd2;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [3:0] checksum_tries;
    } parse_cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] wheel_right_duty;
        logic [DUTY_W-1:0] wheel_left_duty;
        logic [DUTY_W-1:0] collect_duty;
        logic [DUTY_W-1:0] load_duty;
        logic              wheel_right_dir;
        logic              wheel_left_dir;
        logic              collect_dir;
        logic              load_dir;
        logic              shooter_on;
    } result_t;

    function automatic req_t button_req(input logic fwd, input logic rev);
        req_t r;
        if (fwd) begin
            r = REQ_FWD;
        end else if (rev) begin
            r = REQ_REV;
        end else begin
            r = REQ_NONE;
        end
        return r;
    endfunction

    function automatic req_t stick_req(input logic [7:0] x, input logic [7:0] y,
                                       input logic [6:0] lo, input logic [6:0] hi);
        req_t r;
        r = REQ_NONE;
        if ((x < {1'b0, hi}) && (x > {1'b0, lo})) begin
            if (y == STICK_Y_FWD) begin
                r = REQ_FWD;
            end else if (y == STICK_Y_REV) begin
                r = REQ_REV;
            end
        end
        return r;
    endfunction

endpackage

### design/gpmr_frame_parser.sv
// ----------------------------------------------------------------------------
// gpmr_frame_parser
// Start byte hunt, data byte capture and checksum search for one frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpmr_frame_parser
    import gpmr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_DATA_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_valid,
    input  logic [7:0]                  rx_byte,
    input  parse_cfg_t                  cfg,
    output logic                        apply,
    output logic [FRAME_BYTES-1:0][7:0] frame_bytes
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_SUM  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [3:0]       tries_reg, tries_next;
    logic [6:0]       sum_reg, sum_next;
    logic             apply_reg, apply_next;
    logic [7:0]       frame_reg [FRAME_BYTES];

    always_comb begin
        phase_next = phase_reg;
        index_next = index_reg;
        tries_next = tries_reg;
        sum_next   = sum_reg;
        apply_next = 1'b0;
        if (byte_valid) begin
            unique case (phase_reg)
                PH_DATA: begin
                    sum_next = sum_reg + rx_byte[6:0];
                    if (index_reg == LAST_IDX) begin
                        index_next = '0;
                        tries_next = (cfg.checksum_tries != 4'd0) ? cfg.checksum_tries : 4'd1;
                        phase_next = PH_SUM;
                    end else begin
                        index_next = index_reg + 1'b1;
                    end
                end
                PH_SUM: begin
                    if (rx_byte == {1'b0, sum_reg}) begin
                        phase_next = PH_HUNT;
                        tries_next = 4'd0;
                        apply_next = 1'b1;
                    end else begin
                        tries_next = (tries_reg != 4'd0) ? tries_reg - 1'b1 : 4'd0;
                        if (tries_next == 4'd0) begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (rx_byte == cfg.start_byte) begin
                        phase_next = PH_DATA;
                        index_next = '0;
                        sum_next   = 7'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            index_reg <= '0;
            tries_reg <= 4'd0;
            sum_reg   <= 7'd0;
            apply_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            tries_reg <= tries_next;
            sum_reg   <= sum_next;
            apply_reg <= apply_next;
        end
    end

    // Frame bytes are not overwritten before the next start byte, so they stay
    // stable in the cycle after the checksum match.
    always_ff @(posedge aclk) begin
        if (byte_valid && (phase_reg == PH_DATA)) begin
            frame_reg[index_reg] <= rx_byte;
        end
    end

    assign apply = apply_reg;

    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_bytes[i] = frame_reg[i];
        end
    end

endmodule

### design/gpmr_ramp_channel.sv
// ----------------------------------------------------------------------------
// gpmr_ramp_channel
// Duty ramp of one motor channel with forward and reverse trackers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpmr_ramp_channel
    import gpmr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              apply,
    input  logic              clear_duty,
    input  req_t              req,
    input  logic [7:0]        ramp_step,
    input  logic [DUTY_W-1:0] ceiling,
    output logic [DUTY_W-1:0] duty_new,
    output logic              dir_new
);

    localparam logic [DUTY_W-1:0] DUTY_FULL = '1;

    logic [DUTY_W-1:0] actual_reg, actual_next;
    logic [DUTY_W-1:0] fwd_reg, fwd_next;
    logic [DUTY_W-1:0] rev_reg, rev_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              dir_reg, dir_next;
    logic [DUTY_W-1:0] trk, trk_next;

    function automatic logic [DUTY_W-1:0] duty_rise(input logic [DUTY_W-1:0] v,
                                                    input logic [7:0] step);
        logic [DUTY_W:0] s;
        s = {1'b0, v} + (DUTY_W + 1)'(step);
        return (s > {1'b0, DUTY_FULL}) ? DUTY_FULL : s[DUTY_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] duty_fall(input logic [DUTY_W-1:0] v,
                                                    input logic [7:0] step);
        logic [DUTY_W-1:0] st;
        st = DUTY_W'(step);
        return (v > st) ? v - st : '0;
    endfunction

    assign trk = (req == REQ_FWD) ? fwd_reg : rev_reg;

    always_comb begin
        actual_next = actual_reg;
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        duty_next   = clear_duty ? '0 : duty_reg;
        dir_next    = dir_reg;
        trk_next    = trk;
        case (req) inside
            REQ_FWD, REQ_REV: begin
                if (actual_reg == trk) begin
                    if (actual_reg < ceiling) begin
                        actual_next = duty_rise(actual_reg, ramp_step);
                        duty_next   = actual_next;
                        dir_next    = (req == REQ_FWD);
                    end
                    if (trk < ceiling) begin
                        trk_next = duty_rise(trk, ramp_step);
                    end
                end else begin
                    if (actual_reg != '0) begin
                        actual_next = duty_fall(actual_reg, ramp_step);
                        duty_next   = actual_next;
                    end
                    if (trk != '0) begin
                        trk_next = duty_fall(trk, ramp_step);
                    end
                end
            end
            default: begin
                if (actual_reg != '0) begin
                    actual_next = duty_fall(actual_reg, ramp_step);
                    duty_next   = actual_next;
                end
            end
        endcase
        if (req == REQ_FWD) begin
            fwd_next = trk_next;
        end else if (req == REQ_REV) begin
            rev_next = trk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            actual_reg <= '0;
            fwd_reg    <= '0;
            rev_reg    <= '0;
            duty_reg   <= '0;
            dir_reg    <= 1'b0;
        end else if (apply) begin
            actual_reg <= actual_next;
            fwd_reg    <= fwd_next;
            rev_reg    <= rev_next;
            duty_reg   <= duty_next;
            dir_reg    <= dir_next;
        end
    end

    assign duty_new = duty_next;
    assign dir_new  = dir_next;

endmodule

### design/gamepad_packet_motor_ramp.sv
// ----------------------------------------------------------------------------
// gamepad_packet_motor_ramp
// Path: once the checksum byte is accepted, its result word passes the parser
// register, then the skid stage if m_* stalls, then the result register.
// Throughput: one byte per cycle; s_ready drops only when the result register
// and its skid stage would both be taken by unread results.
// Reset: aresetn, synchronous and active low, clears the parser, all ramps,
// trackers, duties, direction bits and the shooter latch, and loads defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamepad_packet_motor_ramp
    import gpmr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_DATA_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUTY_W-1:0]     m_wheel_right_duty,
    output logic [DUTY_W-1:0]     m_wheel_left_duty,
    output logic [DUTY_W-1:0]     m_collect_duty,
    output logic [DUTY_W-1:0]     m_load_duty,
    output logic                  m_wheel_right_dir,
    output logic                  m_wheel_left_dir,
    output logic                  m_collect_dir,
    output logic                  m_load_dir,
    output logic                  m_shooter_on,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index past the
    // last register is ignored.
    // ------------------------------------------------------------------
    logic [7:0]        ramp_step_reg;
    logic [DUTY_W-1:0] wheel_max_reg;
    logic [DUTY_W-1:0] aux_max_reg;
    logic [7:0]        start_byte_reg;
    logic [3:0]        tries_cfg_reg;
    logic [6:0]        stick_low_reg;
    logic [6:0]        stick_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg  <= RST_RAMP_STEP;
            wheel_max_reg  <= RST_WHEEL_MAX;
            aux_max_reg    <= RST_AUX_MAX;
            start_byte_reg <= RST_START_BYTE;
            tries_cfg_reg  <= RST_CHECKSUM_TRIES;
            stick_low_reg  <= RST_STICK_LOW;
            stick_high_reg <= RST_STICK_HIGH;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RAMP_STEP:      ramp_step_reg  <= cfg_data[7:0];
                REG_WHEEL_MAX:      wheel_max_reg  <= cfg_data[DUTY_W-1:0];
                REG_AUX_MAX:        aux_max_reg    <= cfg_data[DUTY_W-1:0];
                REG_START_BYTE:     start_byte_reg <= cfg_data[7:0];
                REG_CHECKSUM_TRIES: tries_cfg_reg  <= cfg_data[3:0];
                REG_STICK_LOW:      stick_low_reg  <= cfg_data[6:0];
                REG_STICK_HIGH:     stick_high_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser stage. It raises apply for one cycle after the byte that
    // matches the frame checksum, with the frame bytes held alongside.
    // ------------------------------------------------------------------
    logic                        in_accept;
    logic                        apply;
    logic [FRAME_BYTES-1:0][7:0] frame_bytes;
    parse_cfg_t                  parse_cfg;

    assign in_accept = s_valid && s_ready;
    assign parse_cfg = '{start_byte: start_byte_reg, checksum_tries: tries_cfg_reg};

    gpmr_frame_parser #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_accept),
        .rx_byte    (s_rx_byte),
        .cfg        (parse_cfg),
        .apply      (apply),
        .frame_bytes(frame_bytes)
    );

    // ------------------------------------------------------------------
    // Ramp stage. Byte 0 carries the shoulder buttons and square, byte 1
    // triangle and circle, bytes 2 and 3 the left stick, 4 and 5 the right.
    // Channels are independent, so all four are updated in the same cycle.
    // ------------------------------------------------------------------
    logic [7:0] b0, b1;
    req_t       req_right, req_left, req_collect, req_load;
    logic       square;

    assign b0          = frame_bytes[0];
    assign b1          = frame_bytes[1];
    assign square      = b0[0];
    assign req_collect = button_req(b0[3], b0[4]);
    assign req_load    = button_req(b0[1], b0[2]);
    assign req_right   = stick_req(frame_bytes[4], frame_bytes[5],
                                   stick_low_reg, stick_high_reg);
    assign req_left    = stick_req(frame_bytes[2], frame_bytes[3],
                                   stick_low_reg, stick_high_reg);

    logic [DUTY_W-1:0] duty_right, duty_left, duty_collect, duty_load;
    logic              dir_right, dir_left, dir_collect, dir_load;

    gpmr_ramp_channel u_ch_right (
        .aclk(aclk), .aresetn(aresetn), .apply(apply), .clear_duty(square),
        .req(req_right), .ramp_step(ramp_step_reg), .ceiling(wheel_max_reg),
        .duty_new(duty_right), .dir_new(dir_right)
    );

    gpmr_ramp_channel u_ch_left (
        .aclk(aclk), .aresetn(aresetn), .apply(apply), .clear_duty(square),
        .req(req_left), .ramp_step(ramp_step_reg), .ceiling(wheel_max_reg),
        .duty_new(duty_left), .dir_new(dir_left)
    );

    gpmr_ramp_channel u_ch_collect (
        .aclk(aclk), .aresetn(aresetn), .apply(apply), .clear_duty(square),
        .req(req_collect), .ramp_step(ramp_step_reg), .ceiling(aux_max_reg),
        .duty_new(duty_collect), .dir_new(dir_collect)
    );

    gpmr_ramp_channel u_ch_load (
        .aclk(aclk), .aresetn(aresetn), .apply(apply), .clear_duty(square),
        .req(req_load), .ramp_step(ramp_step_reg), .ceiling(aux_max_reg),
        .duty_new(duty_load), .dir_new(dir_load)
    );

    // The shooter latch is set by circle and then cleared by triangle, so
    // triangle wins when both are pressed.
    logic shooter_reg, shooter_next;

    always_comb begin
        shooter_next = shooter_reg;
        if (b1[6]) begin
            shooter_next = 1'b1;
        end
        if (b1[4]) begin
            shooter_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shooter_reg <= 1'b0;
        end else if (apply) begin
            shooter_reg <= shooter_next;
        end
    end

    result_t result;

    assign result = '{
        wheel_right_duty: duty_right,
        wheel_left_duty:  duty_left,
        collect_duty:     duty_collect,
        load_duty:        duty_load,
        wheel_right_dir:  dir_right,
        wheel_left_dir:   dir_left,
        collect_dir:      dir_collect,
        load_dir:         dir_load,
        shooter_on:       shooter_next
    };

    // ------------------------------------------------------------------
    // Result register with a skid stage. The input side keeps taking bytes
    // while a result word waits, as long as a slot is free for the one
    // result that the parser may already hold.
    // ------------------------------------------------------------------
    result_t out_reg, skid_reg;
    logic    m_valid_reg, skid_valid_reg;
    logic [1:0] occupancy;

    assign occupancy = {1'b0, m_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, apply};
    assign s_ready   = (occupancy < 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= apply;
                end else begin
                    m_valid_reg    <= apply;
                end
            end else if (apply) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (apply) begin
                    skid_reg <= result;
                end
            end else if (apply) begin
                out_reg <= result;
            end
        end else if (apply) begin
            skid_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_wheel_right_duty = out_reg.wheel_right_duty;
    assign m_wheel_left_duty  = out_reg.wheel_left_duty;
    assign m_collect_duty     = out_reg.collect_duty;
    assign m_load_duty        = out_reg.load_duty;
    assign m_wheel_right_dir  = out_reg.wheel_right_dir;
    assign m_wheel_left_dir   = out_reg.wheel_left_dir;
    assign m_collect_dir      = out_reg.collect_dir;
    assign m_load_dir         = out_reg.load_dir;
    assign m_shooter_on       = out_reg.shooter_on;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The skid stage only fills behind a waiting result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid stage holds a word while the result register is empty");

    // A new result never arrives when both slots are full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (apply && m_valid_reg && !m_ready) |-> !skid_valid_reg)
        else $error("result word arrives with no free slot");

    // A frame is applied only in the cycle after an accepted byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        apply |-> $past(in_accept))
        else $error("frame applied without a preceding checksum byte");

endmodule

### tb/tb_gamepad_packet_motor_ramp.sv
// ----------------------------------------------------------------------------
// tb_gamepad_packet_motor_ramp
// Self-checking bench for the gamepad frame receiver and its four motor ramps.
// Serial bytes are pushed through the valid/ready input with random gaps.
// A scoreboard class tracks the parser, ramps and trackers on its own and
// compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gamepad_packet_motor_ramp;
    import gpmr_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;      // result register plus parser stage, with slack
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 23;
    localparam int LONG_HOLD     = 300;    // receiver back-pressure stretch, in cycles
    localparam int PHASE_BYTES   = 330;
    localparam int PHASE_COUNT   = 6;

    typedef enum logic [1:0] {PARSE_HUNT, PARSE_DATA, PARSE_SUM} parse_state_t;

    // ------------------------------------------------------------------------
    // Frame and ramp tracker. It follows every accepted byte, keeps its own
    // copy of the registers and of the motor state, and queues one expected
    // result word for each frame whose checksum matches.
    // ------------------------------------------------------------------------
    class motor_ramp_scoreboard;
        bit [7:0]          step;
        bit [DUTY_W-1:0]   wheel_ceil;
        bit [DUTY_W-1:0]   aux_ceil;
        bit [7:0]          marker;
        bit [3:0]          tries_cfg;
        bit [6:0]          stick_lo;
        bit [6:0]          stick_hi;

        parse_state_t      state;
        int unsigned       data_idx;
        int unsigned       tries_left;
        bit [7:0]          frame_data [FRAME_DATA_BYTES];
        int unsigned       actual [4];
        int unsigned       trk_fwd [4];
        int unsigned       trk_rev [4];
        int unsigned       duty [4];
        bit [3:0]          dirs;
        bit                shooter;

        result_t           expected_q [$];
        int                errors;
        int                checked;
        int                frames_applied;

        function new();
            step       = RST_RAMP_STEP;
            wheel_ceil = RST_WHEEL_MAX;
            aux_ceil   = RST_AUX_MAX;
            marker     = RST_START_BYTE;
            tries_cfg  = RST_CHECKSUM_TRIES;
            stick_lo   = RST_STICK_LOW;
            stick_hi   = RST_STICK_HIGH;
            state      = PARSE_HUNT;
            data_idx   = 0;
            tries_left = 0;
            foreach (actual[i]) begin
                actual[i]  = 0;
                trk_fwd[i] = 0;
                trk_rev[i] = 0;
                duty[i]    = 0;
            end
            dirs           = '0;
            shooter        = 1'b0;
            errors         = 0;
            checked        = 0;
            frames_applied = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RAMP_STEP:      step       = data[7:0];
                REG_WHEEL_MAX:      wheel_ceil = data[DUTY_W-1:0];
                REG_AUX_MAX:        aux_ceil   = data[DUTY_W-1:0];
                REG_START_BYTE:     marker     = data[7:0];
                REG_CHECKSUM_TRIES: tries_cfg  = data[3:0];
                REG_STICK_LOW:      stick_lo   = data[6:0];
                REG_STICK_HIGH:     stick_hi   = data[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned step_up(int unsigned v);
            int unsigned r;
            r = v + step;
            return (r > 1023) ? 1023 : r;
        endfunction

        function int unsigned step_down(int unsigned v);
            return (v > step) ? v - step : 0;
        endfunction

        // A channel only climbs while its output matches the tracker of the
        // requested direction; otherwise it winds down through zero first.
        function void ramp_channel(int ch, req_t req, int unsigned ceiling);
            int unsigned trk;
            if (req == REQ_NONE) begin
                if (actual[ch] > 0) begin
                    actual[ch] = step_down(actual[ch]);
                    duty[ch]   = actual[ch];
                end
                return;
            end
            trk = (req == REQ_FWD) ? trk_fwd[ch] : trk_rev[ch];
            if (actual[ch] == trk) begin
                if (actual[ch] < ceiling) begin
                    actual[ch] = step_up(actual[ch]);
                    duty[ch]   = actual[ch];
                    dirs[ch]   = (req == REQ_FWD);
                end
                if (trk < ceiling) begin
                    trk = step_up(trk);
                end
            end else begin
                if (actual[ch] > 0) begin
                    actual[ch] = step_down(actual[ch]);
                    duty[ch]   = actual[ch];
                end
                if (trk > 0) begin
                    trk = step_down(trk);
                end
            end
            if (req == REQ_FWD) begin
                trk_fwd[ch] = trk;
            end else begin
                trk_rev[ch] = trk;
            end
        endfunction

        function req_t drive_req(bit [7:0] x, bit [7:0] y);
            if (x < {1'b0, stick_hi} && x > {1'b0, stick_lo}) begin
                if (y == STICK_Y_FWD) begin
                    return REQ_FWD;
                end
                if (y == STICK_Y_REV) begin
                    return REQ_REV;
                end
            end
            return REQ_NONE;
        endfunction

        function void apply_frame();
            req_t    rq;
            result_t w;
            if (frame_data[0][0]) begin
                foreach (duty[i]) begin
                    duty[i] = 0;
                end
            end
            rq = frame_data[0][3] ? REQ_FWD : (frame_data[0][4] ? REQ_REV : REQ_NONE);
            ramp_channel(2, rq, aux_ceil);
            rq = frame_data[0][1] ? REQ_FWD : (frame_data[0][2] ? REQ_REV : REQ_NONE);
            ramp_channel(3, rq, aux_ceil);
            if (frame_data[1][6]) begin
                shooter = 1'b1;
            end
            if (frame_data[1][4]) begin
                shooter = 1'b0;
            end
            ramp_channel(0, drive_req(frame_data[4], frame_data[5]), wheel_ceil);
            ramp_channel(1, drive_req(frame_data[2], frame_data[3]), wheel_ceil);

            w.wheel_right_duty = DUTY_W'(duty[0]);
            w.wheel_left_duty  = DUTY_W'(duty[1]);
            w.collect_duty     = DUTY_W'(duty[2]);
            w.load_duty        = DUTY_W'(duty[3]);
            w.wheel_right_dir  = dirs[0];
            w.wheel_left_dir   = dirs[1];
            w.collect_dir      = dirs[2];
            w.load_dir         = dirs[3];
            w.shooter_on       = shooter;
            expected_q.push_back(w);
            frames_applied++;
        endfunction

        function void note_byte(bit [7:0] b);
            int unsigned total;
            total = 0;
            case (state)
                PARSE_DATA: begin
                    frame_data[data_idx] = b;
                    data_idx++;
                    if (data_idx >= FRAME_DATA_BYTES) begin
                        data_idx   = 0;
                        tries_left = (tries_cfg == 0) ? 1 : tries_cfg;
                        state      = PARSE_SUM;
                    end
                end
                PARSE_SUM: begin
                    foreach (frame_data[i]) begin
                        total += frame_data[i];
                    end
                    if (b == {1'b0, total[6:0]}) begin
                        state      = PARSE_HUNT;
                        tries_left = 0;
                        apply_frame();
                    end else begin
                        if (tries_left > 0) begin
                            tries_left--;
                        end
                        if (tries_left == 0) begin
                            state = PARSE_HUNT;
                        end
                    end
                end
                default: begin
                    data_idx = 0;
                    state    = (b == marker) ? PARSE_DATA : PARSE_HUNT;
                end
            endcase
        endfunction

        function void cmp_field(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, fname, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word with no frame behind it, expected none, got %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            cmp_field("wheel_right_duty", want.wheel_right_duty, got.wheel_right_duty);
            cmp_field("wheel_left_duty",  want.wheel_left_duty,  got.wheel_left_duty);
            cmp_field("collect_duty",     want.collect_duty,     got.collect_duty);
            cmp_field("load_duty",        want.load_duty,        got.load_duty);
            cmp_field("wheel_right_dir",  want.wheel_right_dir,  got.wheel_right_dir);
            cmp_field("wheel_left_dir",   want.wheel_left_dir,   got.wheel_left_dir);
            cmp_field("collect_dir",      want.collect_dir,      got.collect_dir);
            cmp_field("load_dir",         want.load_dir,         got.load_dir);
            cmp_field("shooter_on",       want.shooter_on,       got.shooter_on);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero; reset is held for the first cycles and then released once.
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [DUTY_W-1:0]     m_wheel_right_duty;
    logic [DUTY_W-1:0]     m_wheel_left_duty;
    logic [DUTY_W-1:0]     m_collect_duty;
    logic [DUTY_W-1:0]     m_load_duty;
    logic                  m_wheel_right_dir;
    logic                  m_wheel_left_dir;
    logic                  m_collect_dir;
    logic                  m_load_dir;
    logic                  m_shooter_on;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    gamepad_packet_motor_ramp uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_wheel_right_duty (m_wheel_right_duty),
        .m_wheel_left_duty  (m_wheel_left_duty),
        .m_collect_duty     (m_collect_duty),
        .m_load_duty        (m_load_duty),
        .m_wheel_right_dir  (m_wheel_right_dir),
        .m_wheel_left_dir   (m_wheel_left_dir),
        .m_collect_dir      (m_collect_dir),
        .m_load_dir         (m_load_dir),
        .m_shooter_on       (m_shooter_on),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    motor_ramp_scoreboard sb;

    // Shared bench state. no_idle is owned by the main sequence; the receiver
    // hold counters are owned by the receiver process alone.
    bit          no_idle;
    int          results_seen;
    int          hold_left;
    bit          hold_done;
    int          bytes_sent;
    int          phase_bytes;
    int          reg_writes;
    int          cycle_count;
    result_t     got_word;

    // Held controller state, so that requests persist across frames long
    // enough for the ramps to climb to their ceilings and to reverse.
    bit [7:0]    held_b0;
    bit [15:0]   held_left;
    bit [15:0]   held_right;

    // ------------------------------------------------------------------------
    // Receiver. m_ready changes on the falling edge. It drops at random about
    // a quarter of the time, except while the no-idle stretch is running.
    // Once some results have come back, it holds off for a long stretch so
    // the output stage fills and the block has to stall its byte input.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 30) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every result word taken at a rising edge goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_word.wheel_right_duty = m_wheel_right_duty;
            got_word.wheel_left_duty  = m_wheel_left_duty;
            got_word.collect_duty     = m_collect_duty;
            got_word.load_duty        = m_load_duty;
            got_word.wheel_right_dir  = m_wheel_right_dir;
            got_word.wheel_left_dir   = m_wheel_left_dir;
            got_word.collect_dir      = m_collect_dir;
            got_word.load_dir         = m_load_dir;
            got_word.shooter_on       = m_shooter_on;
            sb.check_result(got_word);
            results_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d result words still pending",
                 cycle_count, sb.expected_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers. Both are entered at a falling edge and return at one, and they
    // never lower valid before raising it again in the same step.
    // ------------------------------------------------------------------------

    // Offers one byte, with a random gap first, and waits until it is taken.
    task automatic send_byte(input bit [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_byte(b);
        bytes_sent++;
        phase_bytes++;
        @(negedge aclk);
    endtask

    // Writes one register; cfg_valid stays up for the next write in a batch
    // and is lowered by the caller once the batch is done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        sb.write_reg(idx, CFG_DATA_W'(value));
        reg_writes++;
        @(negedge aclk);
    endtask

    task automatic program_regs(input int unsigned step, input int unsigned wheel_ceil,
                                input int unsigned aux_ceil, input int unsigned marker,
                                input int unsigned tries, input int unsigned lo,
                                input int unsigned hi);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_WHEEL_MAX, wheel_ceil);
        write_reg(REG_AUX_MAX, aux_ceil);
        write_reg(REG_START_BYTE, marker);
        write_reg(REG_CHECKSUM_TRIES, tries);
        write_reg(REG_STICK_LOW, lo);
        write_reg(REG_STICK_HIGH, hi);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Registers only change with the block idle: the byte input is withdrawn,
    // every expected word is back, and a few cycles pass for a frame that was
    // dropped without a result.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Sends a start byte, six data bytes, a number of wrong checksum
    // candidates and, if asked, the right checksum. With marker_first set,
    // the first wrong candidate is the start byte, unless that is the checksum.
    task automatic send_frame(input bit [5:0][7:0] fd, input int misses,
                              input bit complete, input bit marker_first);
        int unsigned total;
        bit [7:0]    chk;
        bit [7:0]    junk;
        total = 0;
        for (int i = 0; i < FRAME_DATA_BYTES; i++) begin
            total += fd[i];
        end
        chk = {1'b0, total[6:0]};
        send_byte(sb.marker);
        for (int i = 0; i < FRAME_DATA_BYTES; i++) begin
            send_byte(fd[i]);
        end
        for (int k = 0; k < misses; k++) begin
            if (k == 0 && marker_first && sb.marker != chk) begin
                junk = sb.marker;
            end else begin
                junk = 8'($urandom);
                while (junk == chk) begin
                    junk = 8'($urandom);
                end
            end
            send_byte(junk);
        end
        if (complete) begin
            send_byte(chk);
        end
    endtask

    // Stick position: mostly inside the drive window with y at full forward
    // or full reverse, the rest anywhere.
    function automatic bit [15:0] pick_stick();
        bit [7:0]    x;
        bit [7:0]    y;
        int unsigned lo1;
        int          roll;
        lo1 = sb.stick_lo + 1;
        if (sb.stick_hi >= lo1 + 1 && $urandom_range(0, 99) < 75) begin
            x = 8'($urandom_range(lo1, sb.stick_hi - 1));
        end else begin
            x = 8'($urandom);
        end
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            y = STICK_Y_FWD;
        end else if (roll < 8) begin
            y = STICK_Y_REV;
        end else begin
            y = 8'($urandom);
        end
        return {x, y};
    endfunction

    // One random frame. Controls drift slowly, the button byte for triangle
    // and circle is fresh each time, and the checksum trailer is clean,
    // delayed by wrong candidates, or missing so the frame is dropped. Now
    // and then a burst of line noise comes first.
    task automatic random_frame();
        bit [5:0][7:0] fd;
        int unsigned   n_tries;
        int            roll;
        n_tries = (sb.tries_cfg == 0) ? 1 : sb.tries_cfg;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
        if ($urandom_range(0, 99) < 20) begin
            held_b0    = 8'($urandom);
            held_b0[0] = ($urandom_range(0, 7) == 0);
        end
        if ($urandom_range(0, 99) < 20) begin
            held_left = pick_stick();
        end
        if ($urandom_range(0, 99) < 20) begin
            held_right = pick_stick();
        end
        fd[0]    = held_b0;
        fd[1]    = 8'($urandom);
        fd[1][6] = ($urandom_range(0, 99) < 30);
        fd[1][4] = ($urandom_range(0, 99) < 25);
        fd[2]    = held_left[15:8];
        fd[3]    = held_left[7:0];
        fd[4]    = held_right[15:8];
        fd[5]    = held_right[7:0];
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            send_frame(fd, n_tries, 1'b0, 1'($urandom_range(0, 1)));
        end else if (roll < 60) begin
            send_frame(fd, 0, 1'b1, 1'b0);
        end else begin
            send_frame(fd, $urandom_range(0, n_tries - 1), 1'b1,
                       ($urandom_range(0, 99) < 30));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, a few hand-built frames on the reset settings,
    // then several register settings, each followed by a run of random
    // frames. The fifth setting runs both sides without any idling.
    // ------------------------------------------------------------------------
    initial begin
        sb          = new();
        no_idle     = 1'b0;
        held_b0     = '0;
        held_left   = '0;
        held_right  = '0;
        bytes_sent  = 0;
        phase_bytes = 0;
        reg_writes  = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // R1 and L1 forward, circle, both sticks just inside the window, one
        // forward and one reverse. The start byte shows up as a wrong
        // checksum candidate before the real one.
        send_frame({8'h7F, 8'h76, 8'h00, 8'h0B, 8'h40, 8'h0A}, 1, 1'b1, 1'b1);
        // Square with R2 and L2, circle and triangle together, both sticks
        // sitting exactly on the window edges so they do not drive.
        send_frame({8'h7F, 8'h77, 8'h00, 8'h0A, 8'h50, 8'h15}, 0, 1'b1, 1'b0);
        // Every bit set in every data byte.
        send_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0, 1'b1, 1'b0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    // Largest step and ceilings, start byte zero, one try,
                    // the stick window wide open.
                    1: program_regs(255, 1023, 1023, 0, 1, 0, 127);
                    // Smallest nonzero step, zero wheel ceiling, an empty stick
                    // window and the most checksum tries.
                    2: program_regs(1, 0, 7, 255, 15, 127, 0);
                    // Zero step freezes the ramps; zero tries acts as one.
                    3: program_regs(0, 500, 300, 85, 0, 20, 100);
                    // A wheel ceiling that is not a multiple of the step.
                    4: program_regs(100, 250, 1000, $urandom_range(0, 255),
                                    $urandom_range(1, 15), 10, 119);
                    default: program_regs($urandom_range(1, 255), $urandom_range(0, 1023),
                                          $urandom_range(0, 1023), $urandom_range(0, 255),
                                          $urandom_range(0, 15), $urandom_range(0, 60),
                                          $urandom_range(64, 127));
                endcase
            end
            no_idle     = (ph == 4);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                random_frame();
            end
        end
        no_idle = 1'b0;

        wait_drained();

        $display("Sent %0d bytes under %0d register settings with %0d register writes.",
                 bytes_sent, PHASE_COUNT, reg_writes);
        $display("%0d frames applied, %0d result words checked, long receiver stall %s.",
                 sb.frames_applied, sb.checked, hold_done ? "seen" : "not reached");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
design/gpmr_pkg.sv
design/gpmr_frame_parser.sv
design/gpmr_ramp_channel.sv
design/gamepad_packet_motor_ramp.sv
tb/tb_gamepad_packet_motor_ramp.sv
